### hw/rtl/lcdf_pkg.sv
// ----------------------------------------------------------------------------
// lcdf_pkg
// Shared types, constants and helpers of the dithering LCD framer.
// ----------------------------------------------------------------------------
package lcdf_pkg;

   localparam int unsigned DEF_MAX_ROW_PIXELS = 4096;
   localparam int unsigned QUEUE_DEPTH        = 4;

   localparam int unsigned BPL_W  = 7;
   localparam int unsigned LC_W   = 8;
   localparam int unsigned SRP_W  = 13;
   localparam int unsigned CSR_IW = 2;

   localparam logic [CSR_IW-1:0] CSR_BYTES_PER_LINE    = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_LINE_COUNT        = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_SOURCE_ROW_PIXELS = 2'd2;

   localparam logic [BPL_W-1:0] RST_BYTES_PER_LINE    = 7'd50;
   localparam logic [LC_W-1:0]  RST_LINE_COUNT        = 8'd240;
   localparam logic [SRP_W-1:0] RST_SOURCE_ROW_PIXELS = 13'd400;

   localparam logic [7:0] CMD_VCOM_LOW  = 8'h80;
   localparam logic [7:0] CMD_VCOM_HIGH = 8'hC0;
   localparam logic [7:0] FILL_BYTE     = 8'h00;
   localparam logic [7:0] FIRST_BIT     = 8'b1000_0000;

   // floor(s/3) == (s*683)>>11 for s <= 765
   localparam logic [9:0] RECIP3       = 10'd683;
   localparam int unsigned RECIP3_SHIFT = 11;

   localparam logic [5:0] BAYER [8][8] = '{
      '{6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42},
      '{6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26},
      '{6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38},
      '{6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22},
      '{6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41},
      '{6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25},
      '{6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37},
      '{6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21}
   };

   typedef struct packed {
      logic [BPL_W-1:0] bytes_per_line;
      logic [LC_W-1:0]  line_count;
      logic [SRP_W-1:0] source_row_pixels;
   } cfg_type;

   // up to three bytes, data[0] goes out first
   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      count;
      logic            ends;
   } entry_type;

   function automatic logic [7:0] bit_reverse(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

endpackage

### hw/rtl/lcdf_front.sv
// ----------------------------------------------------------------------------
// lcdf_front
// Pixel intake: dither, pack, track position and build queue entries.
// ----------------------------------------------------------------------------
module lcdf_front
   import lcdf_pkg::*;
#(
   parameter int unsigned MAX_ROW_PIXELS = DEF_MAX_ROW_PIXELS
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      req_valid,
   output logic      req_stall,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   input  logic      req_frame_start,
   input  logic      q_full,
   output logic      q_push,
   output entry_type q_entry
);

   localparam int unsigned COL_W = $clog2(MAX_ROW_PIXELS);
   localparam int unsigned CMP_W = (COL_W + 1 > 14) ? COL_W + 1 : 14;
   localparam int unsigned WID_W = BPL_W + 3;
   localparam logic [CMP_W-1:0] ROW_LIMIT = CMP_W'(MAX_ROW_PIXELS);

   logic [COL_W-1:0] col_ff, col_in;
   logic [7:0]       line_ff, line_in;
   logic [7:0]       pack_ff, pack_in;
   logic             vcom_ff, vcom_in;
   logic             done_ff, done_in;

   logic             accept;
   logic [COL_W-1:0] col0;
   logic [7:0]       line0;
   logic [7:0]       pack0;
   logic             done0;
   logic [BPL_W-1:0] bpl;
   logic [WID_W-1:0] width;
   logic [7:0]       lines;
   logic [CMP_W-1:0] row;
   logic [CMP_W-1:0] x_ext;
   logic             in_panel;
   logic [9:0]       sum;
   logic [19:0]      prod;
   logic [8:0]       level;
   logic [5:0]       thr;
   logic [7:0]       pack_new;
   logic             byte_end;
   logic             line_end;
   logic             more;
   entry_type        entry;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept && (entry.count != 2'd0);
   assign q_entry   = entry;

   always_comb begin
      col0  = req_frame_start ? '0 : col_ff;
      line0 = req_frame_start ? 8'd0 : line_ff;
      pack0 = req_frame_start ? 8'd0 : pack_ff;
      done0 = req_frame_start ? 1'b0 : done_ff;

      bpl   = (cfg.bytes_per_line == '0) ? BPL_W'(1) : cfg.bytes_per_line;
      width = {bpl, 3'b000};
      lines = (cfg.line_count == '0) ? 8'd1 : cfg.line_count;
      row   = CMP_W'(cfg.source_row_pixels);
      if (row < CMP_W'(width)) begin
         row = CMP_W'(width);
      end
      if (row > ROW_LIMIT) begin
         row = ROW_LIMIT;
      end

      x_ext    = CMP_W'(col0);
      in_panel = !done0 && (x_ext < CMP_W'(width));

      sum   = 10'(req_red) + 10'(req_green) + 10'(req_blue);
      prod  = 20'(sum) * 20'(RECIP3);
      level = (9'(prod[RECIP3_SHIFT +: 8]) + 9'd1) >> 2;
      thr   = BAYER[col0[2:0]][line0[2:0]];

      pack_new = pack0;
      if (level > 9'(thr)) begin
         pack_new = pack0 | (FIRST_BIT >> col0[2:0]);
      end

      byte_end = in_panel && (col0[2:0] == 3'd7);
      line_end = byte_end && (x_ext == CMP_W'(width) - CMP_W'(1));
      more     = (9'(line0) + 9'd1) < 9'(lines);

      entry = '0;
      if (req_frame_start) begin
         entry.data[0] = vcom_ff ? CMD_VCOM_HIGH : CMD_VCOM_LOW;
         entry.data[1] = bit_reverse(8'd1);
         entry.count   = 2'd2;
      end else if (byte_end) begin
         entry.data[0] = pack_new;
         entry.data[1] = FILL_BYTE;
         entry.data[2] = more ? bit_reverse(line0 + 8'd2) : FILL_BYTE;
         entry.count   = line_end ? 2'd3 : 2'd1;
         entry.ends    = line_end && !more;
      end

      col_in  = col0;
      line_in = line0;
      pack_in = pack0;
      done_in = done0;
      vcom_in = req_frame_start ? !vcom_ff : vcom_ff;
      if (!done0) begin
         if (in_panel) begin
            pack_in = byte_end ? 8'd0 : pack_new;
         end
         if (line_end && !more) begin
            done_in = 1'b1;
         end
         if ((x_ext + CMP_W'(1)) >= row) begin
            col_in  = '0;
            line_in = line0 + 8'd1;
         end else begin
            col_in = col0 + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         line_ff <= 8'd0;
         pack_ff <= 8'd0;
         vcom_ff <= 1'b0;
         done_ff <= 1'b1;
      end else if (accept) begin
         col_ff  <= col_in;
         line_ff <= line_in;
         pack_ff <= pack_in;
         vcom_ff <= vcom_in;
         done_ff <= done_in;
      end
   end

endmodule

### hw/rtl/lcdf_queue.sv
// ----------------------------------------------------------------------------
// lcdf_queue
// Short entry queue between pixel intake and byte serializer.
// ----------------------------------------------------------------------------
module lcdf_queue
   import lcdf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      nonempty,
   output entry_type head
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign nonempty = (cnt_ff != '0);
   assign head     = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

### hw/rtl/lcdf_back.sv
// ----------------------------------------------------------------------------
// lcdf_back
// Byte serializer: walk queue entries into the output register, one byte a cycle unless stalled.
// ----------------------------------------------------------------------------
module lcdf_back
   import lcdf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_nonempty,
   input  entry_type  q_head,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_spi_byte,
   output logic       rsp_last,
   output logic       rsp_transfer_end
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       end_ff;

   logic out_free;
   logic take;
   logic last_byte;

   assign out_free  = !valid_ff || !rsp_stall;
   assign take      = out_free && q_nonempty;
   assign last_byte = (idx_ff == (q_head.count - 2'd1));
   assign q_pop     = take && last_byte;

   assign rsp_valid        = valid_ff;
   assign rsp_spi_byte     = byte_ff;
   assign rsp_last         = last_ff;
   assign rsp_transfer_end = end_ff;

   always_comb begin
      valid_in = out_free ? q_nonempty : valid_ff;
      idx_in   = idx_ff;
      if (take) begin
         idx_in = last_byte ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= q_head.data[idx_ff];
         last_ff <= last_byte;
         end_ff  <= last_byte && q_head.ends;
      end
   end

endmodule

### hw/rtl/rgb_to_memory_lcd_dither_framer.sv
// ----------------------------------------------------------------------------
// rgb_to_memory_lcd_dither_framer
// RGB888 raster pixels in, ordered-dither memory-LCD SPI byte stream out.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one RGB888 pixel per transaction in raster order; frame_start
//   marks the first pixel of a source frame. rsp_* gives one SPI byte per
//   transaction: command, per line address / data / dummy, then trailer.
//   rsp_last flags the final byte caused by one pixel, rsp_transfer_end the
//   final byte of a frame. csr_* writes bytes_per_line, line_count and
//   source_row_pixels; the user must write them only while the block is idle,
//   since the block itself does not enforce it.
// Output: bytes of each pixel pass through the queue, then the output register.
// Throughput: one pixel per cycle while req_stall is low, one output byte per cycle
//   while rsp_stall is low. A pixel gives zero to three bytes; line ends give three,
//   held in a four-entry queue; the byte serializer draining it sets the pixel rate.
// Reset: position clears, VCOM phase low, pixels dropped until frame_start;
//   registers return to 50 bytes, 240 lines, 400 pixels per row.
// Stall: rsp_stall holds the output byte; the queue fills and then
//   req_stall rises until space frees.
// ----------------------------------------------------------------------------
module rgb_to_memory_lcd_dither_framer
   import lcdf_pkg::*;
#(
   parameter int unsigned MAX_ROW_PIXELS = DEF_MAX_ROW_PIXELS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_red,
   input  logic [7:0]        req_green,
   input  logic [7:0]        req_blue,
   input  logic              req_frame_start,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_spi_byte,
   output logic              rsp_last,
   output logic              rsp_transfer_end,
   input  logic              csr_write,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [SRP_W-1:0]  csr_data
);

   cfg_type   cfg_ff;
   logic      q_full;
   logic      q_push;
   logic      q_pop;
   logic      q_nonempty;
   entry_type q_entry;
   entry_type q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bytes_per_line    <= RST_BYTES_PER_LINE;
         cfg_ff.line_count        <= RST_LINE_COUNT;
         cfg_ff.source_row_pixels <= RST_SOURCE_ROW_PIXELS;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BYTES_PER_LINE:    cfg_ff.bytes_per_line    <= csr_data[BPL_W-1:0];
            CSR_LINE_COUNT:        cfg_ff.line_count        <= csr_data[LC_W-1:0];
            CSR_SOURCE_ROW_PIXELS: cfg_ff.source_row_pixels <= csr_data;
            default: begin
            end
         endcase
      end
   end

   lcdf_front #(
      .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_frame_start (req_frame_start),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_entry         (q_entry)
   );

   lcdf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .nonempty   (q_nonempty),
      .head       (q_head)
   );

   lcdf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_nonempty       (q_nonempty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_spi_byte     (rsp_spi_byte),
      .rsp_last         (rsp_last),
      .rsp_transfer_end (rsp_transfer_end)
   );

`ifndef SYNTH
   a_frame_start_pushes: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_frame_start |-> q_push)
      else $error("frame start transaction produced no queue entry");

   a_end_only_on_line_end: assert property (@(posedge clock) disable iff (reset)
      q_push && q_entry.ends |-> q_entry.count == 2'd3)
      else $error("transfer end outside a line end entry");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_transfer_end |-> rsp_last)
      else $error("transfer end byte not flagged last");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");
`endif

endmodule
